>>> rtl/core/olh_pkg.sv
`default_nettype none

package olh_pkg;

   // fixed field widths of the request and response items
   localparam int FUNC_W      = 3;
   localparam int HANDLE_IN_W = 32;
   localparam int POS_W       = 5;
   localparam int STATUS_W    = 2;
   localparam int COUNT_OUT_W = 5;

   // function codes
   localparam logic [FUNC_W-1:0] FUNC_FIND       = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_ADD        = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_REMOVE     = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_REMOVE_ALL = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_INSERT     = 3'd4;
   localparam logic [FUNC_W-1:0] FUNC_ASSIGN     = 3'd5;
   localparam logic [FUNC_W-1:0] FUNC_EXCHANGE   = 3'd6;

   // response status codes
   localparam logic [STATUS_W-1:0] STAT_DONE    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_REFUSED = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_SHDN_CHK,
      ST_SHDN_WR,
      ST_SHUP_CHK,
      ST_SHUP_WR,
      ST_PUT,
      ST_XCH_RD0,
      ST_XCH_RD1,
      ST_XCH_WR0,
      ST_XCH_WR1,
      ST_RESP
   } state_type;

   typedef enum logic [2:0] {
      MODE_FIND,
      MODE_ADD,
      MODE_REMOVE,
      MODE_INSERT,
      MODE_ASSIGN,
      MODE_XCH
   } mode_type;

   typedef enum logic [1:0] {
      WSRC_HANDLE,
      WSRC_RDATA,
      WSRC_TMP
   } wsrc_type;

   typedef struct packed {
      logic     hnd_load;
      logic     rd_en;
      logic     wr_en;
      wsrc_type wr_src;
      logic     tmp_load;
   } store_ctrl_type;

endpackage

`default_nettype wire

>>> rtl/core/olh_store.sv
`default_nettype none

module olh_store
   import olh_pkg::*;
#(
   parameter int DEPTH    = 16,
   parameter int HANDLE_W = 32,
   localparam int AW      = $clog2(DEPTH)
) (
   input  wire logic                clock,
   input  wire store_ctrl_type      ctrl,
   input  wire logic [AW-1:0]       mem_addr,
   input  wire logic [HANDLE_W-1:0] handle,
   output logic                     match
);

   logic [HANDLE_W-1:0] entries_ff [DEPTH];
   logic [HANDLE_W-1:0] rd_data_ff;
   logic [HANDLE_W-1:0] hnd_ff;
   logic [HANDLE_W-1:0] tmp_ff;
   logic [HANDLE_W-1:0] wr_data;

   always_comb begin
      case (ctrl.wr_src)
         WSRC_HANDLE: wr_data = hnd_ff;
         WSRC_RDATA:  wr_data = rd_data_ff;
         WSRC_TMP:    wr_data = tmp_ff;
         default:     wr_data = hnd_ff;
      endcase
   end

   // single port: one read or one write per cycle, read data registered
   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         entries_ff[mem_addr] <= wr_data;
      end
      if (ctrl.rd_en) begin
         rd_data_ff <= entries_ff[mem_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.hnd_load) begin
         hnd_ff <= handle;
      end
      if (ctrl.tmp_load) begin
         tmp_ff <= rd_data_ff;
      end
   end

   // shared comparator, used by every scan step
   assign match = (rd_data_ff == hnd_ff);

endmodule

`default_nettype wire

>>> rtl/core/olh_seq.sv
`default_nettype none

module olh_seq
   import olh_pkg::*;
#(
   parameter int DEPTH = 16,
   localparam int AW   = $clog2(DEPTH),
   localparam int CW   = $clog2(DEPTH + 1),
   localparam int XW   = (CW > POS_W) ? CW : POS_W
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   frozen,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [FUNC_W-1:0]      req_func,
   input  wire logic [POS_W-1:0]       req_position,
   input  wire logic [POS_W-1:0]       req_other_position,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [STATUS_W-1:0]         rsp_status,
   output logic [COUNT_OUT_W-1:0]      rsp_entry_count,
   output store_ctrl_type              ctrl,
   output logic [AW-1:0]               mem_addr,
   input  wire logic                   match
);

   state_type                state_ff, state_in;
   mode_type                 mode_ff, mode_in;
   logic [CW-1:0]            idx_ff, idx_in;
   logic [CW-1:0]            count_ff, count_in;
   logic [POS_W-1:0]         pos_ff, pos_in;
   logic [POS_W-1:0]         pos2_ff, pos2_in;
   logic [STATUS_W-1:0]      status_ff, status_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]      rsp_status_ff, rsp_status_in;
   logic [COUNT_OUT_W-1:0]   rsp_count_ff, rsp_count_in;

   logic [XW-1:0] idx_x, nxt_x, prv_x, cnt_x, pos_x, pos2_x, rp_x, rp2_x;
   logic          full;

   assign idx_x  = XW'(idx_ff);
   assign nxt_x  = idx_x + XW'(1);
   assign prv_x  = idx_x - XW'(1);
   assign cnt_x  = XW'(count_ff);
   assign pos_x  = XW'(pos_ff);
   assign pos2_x = XW'(pos2_ff);
   assign rp_x   = XW'(req_position);
   assign rp2_x  = XW'(req_other_position);
   assign full   = (count_ff == CW'(DEPTH));

   assign req_ready       = (state_ff == ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_count = rsp_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_FIND;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      pos_ff        <= pos_in;
      pos2_ff       <= pos2_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      idx_in        = idx_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      pos2_in       = pos2_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      ctrl          = '0;
      mem_addr      = idx_x[AW-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ctrl.hnd_load = 1'b1;
               pos_in        = req_position;
               pos2_in       = req_other_position;
               idx_in        = '0;
               status_in     = STAT_REFUSED;
               state_in      = ST_RESP;
               case (req_func)
                  FUNC_FIND: begin
                     mode_in  = MODE_FIND;
                     state_in = ST_SCAN_RD;
                  end
                  FUNC_ADD: begin
                     mode_in  = MODE_ADD;
                     state_in = ST_SCAN_RD;
                  end
                  FUNC_REMOVE: begin
                     if (!frozen) begin
                        mode_in  = MODE_REMOVE;
                        state_in = ST_SCAN_RD;
                     end
                  end
                  FUNC_REMOVE_ALL: begin
                     if (!frozen) begin
                        count_in  = '0;
                        status_in = STAT_DONE;
                     end
                  end
                  FUNC_INSERT: begin
                     if (rp_x < cnt_x) begin
                        mode_in = MODE_INSERT;
                        if (!frozen) begin
                           state_in = ST_SCAN_RD;
                        end else if (full) begin
                           status_in = STAT_FULL;
                        end else begin
                           idx_in   = count_ff;
                           state_in = ST_SHUP_CHK;
                        end
                     end else if (rp_x == cnt_x) begin
                        mode_in  = MODE_ADD;
                        state_in = ST_SCAN_RD;
                     end
                  end
                  FUNC_ASSIGN: begin
                     if (rp_x < cnt_x) begin
                        mode_in  = MODE_ASSIGN;
                        idx_in   = rp_x[CW-1:0];
                        state_in = ST_PUT;
                     end else begin
                        mode_in  = MODE_ADD;
                        state_in = ST_SCAN_RD;
                     end
                  end
                  FUNC_EXCHANGE: begin
                     if (rp_x < cnt_x && rp2_x < cnt_x) begin
                        mode_in  = MODE_XCH;
                        state_in = ST_XCH_RD0;
                     end
                  end
                  default: begin
                     state_in = ST_RESP;
                  end
               endcase
            end
         end

         ST_SCAN_RD: begin
            if (idx_x < cnt_x) begin
               ctrl.rd_en = 1'b1;
               state_in   = ST_SCAN_CMP;
            end else begin
               // handle not held
               status_in = STAT_REFUSED;
               state_in  = ST_RESP;
               case (mode_ff)
                  MODE_ADD: begin
                     if (full) begin
                        status_in = STAT_FULL;
                     end else begin
                        idx_in   = count_ff;
                        state_in = ST_PUT;
                     end
                  end
                  MODE_INSERT: begin
                     if (full) begin
                        status_in = STAT_FULL;
                     end else begin
                        idx_in   = count_ff;
                        state_in = ST_SHUP_CHK;
                     end
                  end
                  default: begin
                     state_in = ST_RESP;
                  end
               endcase
            end
         end

         ST_SCAN_CMP: begin
            if (match) begin
               case (mode_ff)
                  MODE_FIND: begin
                     status_in = STAT_DONE;
                     state_in  = ST_RESP;
                  end
                  MODE_REMOVE, MODE_INSERT: begin
                     state_in = ST_SHDN_CHK;
                  end
                  default: begin
                     status_in = STAT_REFUSED;
                     state_in  = ST_RESP;
                  end
               endcase
            end else begin
               idx_in   = nxt_x[CW-1:0];
               state_in = ST_SCAN_RD;
            end
         end

         ST_SHDN_CHK: begin
            if (nxt_x < cnt_x) begin
               ctrl.rd_en = 1'b1;
               mem_addr   = nxt_x[AW-1:0];
               state_in   = ST_SHDN_WR;
            end else begin
               count_in = count_ff - CW'(1);
               if (mode_ff == MODE_INSERT) begin
                  idx_in   = count_ff - CW'(1);
                  state_in = ST_SHUP_CHK;
               end else begin
                  status_in = STAT_DONE;
                  state_in  = ST_RESP;
               end
            end
         end

         ST_SHDN_WR: begin
            ctrl.wr_en  = 1'b1;
            ctrl.wr_src = WSRC_RDATA;
            idx_in      = nxt_x[CW-1:0];
            state_in    = ST_SHDN_CHK;
         end

         ST_SHUP_CHK: begin
            if (idx_x > pos_x) begin
               ctrl.rd_en = 1'b1;
               mem_addr   = prv_x[AW-1:0];
               state_in   = ST_SHUP_WR;
            end else begin
               state_in = ST_PUT;
            end
         end

         ST_SHUP_WR: begin
            ctrl.wr_en  = 1'b1;
            ctrl.wr_src = WSRC_RDATA;
            idx_in      = prv_x[CW-1:0];
            state_in    = ST_SHUP_CHK;
         end

         ST_PUT: begin
            ctrl.wr_en  = 1'b1;
            ctrl.wr_src = WSRC_HANDLE;
            if (mode_ff != MODE_ASSIGN) begin
               count_in = count_ff + CW'(1);
            end
            status_in = STAT_DONE;
            state_in  = ST_RESP;
         end

         ST_XCH_RD0: begin
            ctrl.rd_en = 1'b1;
            mem_addr   = pos_x[AW-1:0];
            state_in   = ST_XCH_RD1;
         end

         ST_XCH_RD1: begin
            ctrl.tmp_load = 1'b1;
            ctrl.rd_en    = 1'b1;
            mem_addr      = pos2_x[AW-1:0];
            state_in      = ST_XCH_WR0;
         end

         ST_XCH_WR0: begin
            ctrl.wr_en  = 1'b1;
            ctrl.wr_src = WSRC_RDATA;
            mem_addr    = pos_x[AW-1:0];
            state_in    = ST_XCH_WR1;
         end

         ST_XCH_WR1: begin
            ctrl.wr_en  = 1'b1;
            ctrl.wr_src = WSRC_TMP;
            mem_addr    = pos2_x[AW-1:0];
            status_in   = STAT_DONE;
            state_in    = ST_RESP;
         end

         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_count_in  = cnt_x[COUNT_OUT_W-1:0];
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count above depth");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |=> count_ff == $past(count_ff)
         || count_ff == $past(count_ff) + CW'(1)
         || count_ff == $past(count_ff) - CW'(1))
      else $error("entry count moved by more than one during an operation");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RESP && status_ff == STAT_FULL |-> full)
      else $error("full status with room left");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff != ST_IDLE)
      else $error("sequencer idle right after an accepted item");

endmodule

`default_nettype wire

>>> rtl/core/ordered_unique_handle_list.sv
// Ordered list of up to DEPTH handles held in a single-port memory, with
// find, add (no duplicates), remove (first match, gap closed), remove all,
// insert at a position, assign to a position and exchange of two positions.
// One item is worked at a time. Every scan step and every entry moved takes
// a read state and then a compare or write state, because the one memory
// port has a registered read. The slowest insert is a handle not yet held
// placed at position 0 (full scan, then every entry shifted up). Assign
// inside the list writes its position directly; exchange inside the list
// reads both positions, then writes both. The next item is taken as soon
// as the sequencer is back to idle, while the last response may still
// wait in the output register. The frozen register blocks remove and
// remove all; it must only be written while the block is idle. Entries past
// the fill count are never read, so the memory needs no clearing after reset.

`default_nettype none

module ordered_unique_handle_list
   import olh_pkg::*;
#(
   parameter int DEPTH    = 16,
   parameter int HANDLE_W = 32
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   // request channel
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic [FUNC_W-1:0]       req_func,
   input  wire logic [HANDLE_IN_W-1:0]  req_handle,
   input  wire logic [POS_W-1:0]        req_position,
   input  wire logic [POS_W-1:0]        req_other_position,
   // response channel
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic [STATUS_W-1:0]          rsp_status,
   output logic [COUNT_OUT_W-1:0]       rsp_entry_count,
   // frozen flag
   input  wire logic                    csr_wr_en,
   input  wire logic                    csr_wr_data
);

   localparam int AW = $clog2(DEPTH);

   logic                frozen_ff, frozen_in;
   store_ctrl_type      ctrl;
   logic [AW-1:0]       mem_addr;
   logic [HANDLE_W-1:0] handle;
   logic                match;

   // handle kept to the configured width
   assign handle = HANDLE_W'(req_handle);

   assign frozen_in = csr_wr_en ? csr_wr_data : frozen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frozen_ff <= 1'b0;
      end else begin
         frozen_ff <= frozen_in;
      end
   end

   // sequencer: decode, scan, shift passes and response register
   olh_seq #(
      .DEPTH (DEPTH)
   ) u_seq (
      .clock              (clock),
      .reset              (reset),
      .frozen             (frozen_ff),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_func           (req_func),
      .req_position       (req_position),
      .req_other_position (req_other_position),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_entry_count    (rsp_entry_count),
      .ctrl               (ctrl),
      .mem_addr           (mem_addr),
      .match              (match)
   );

   // entry memory with the shared comparator and swap holding register
   olh_store #(
      .DEPTH    (DEPTH),
      .HANDLE_W (HANDLE_W)
   ) u_store (
      .clock    (clock),
      .ctrl     (ctrl),
      .mem_addr (mem_addr),
      .handle   (handle),
      .match    (match)
   );

endmodule

`default_nettype wire

>>> tb/tb_ordered_unique_handle_list.sv
`timescale 1ns / 100ps

module tb_ordered_unique_handle_list;
   import olh_pkg::*;

   localparam int DEPTH         = 16;
   localparam int NUM_DIR       = 25;
   localparam int NUM_PHASES    = 7;
   localparam int PHASE_ITEMS   = 200;
   localparam int POOL_SIZE     = 20;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 4;
   localparam int TAIL_CYCLES   = 40;
   localparam int MAX_REPORTS   = 10;

   // code 7 has no package name: the block ignores it and refuses
   localparam logic [FUNC_W-1:0] FUNC_UNDEF = 3'd7;

   // frozen setting per random phase, both extremes appear
   localparam logic [NUM_PHASES-1:0] PHASE_FROZEN = 7'b0100110;

   typedef struct packed {
      logic [FUNC_W-1:0]      func;
      logic [HANDLE_IN_W-1:0] handle;
      logic [POS_W-1:0]       pos;
      logic [POS_W-1:0]       other_pos;
   } list_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]    status;
      logic [COUNT_OUT_W-1:0] count;
   } list_rsp_type;

   // one directed row: optional frozen write before it, the item, and a
   // hand-typed outcome where it is obvious
   typedef struct packed {
      logic                   set_cfg;
      logic                   cfg_val;
      logic [FUNC_W-1:0]      func;
      logic [HANDLE_IN_W-1:0] handle;
      logic [POS_W-1:0]       pos;
      logic [POS_W-1:0]       other_pos;
      logic                   fixed_exp;
      logic [STATUS_W-1:0]    status;
      logic [COUNT_OUT_W-1:0] count;
   } dir_row_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   // request channel
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [FUNC_W-1:0]      req_func = '0;
   logic [HANDLE_IN_W-1:0] req_handle = '0;
   logic [POS_W-1:0]       req_position = '0;
   logic [POS_W-1:0]       req_other_position = '0;

   // response channel
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [STATUS_W-1:0]    rsp_status;
   logic [COUNT_OUT_W-1:0] rsp_entry_count;

   // frozen register write port
   logic csr_wr_en = 1'b0;
   logic csr_wr_data = 1'b0;

   // shadow copy of the list, updated at every accepted item
   logic [HANDLE_IN_W-1:0] shadow_entries [DEPTH];
   int                     shadow_count;
   logic                   shadow_frozen;

   // outcomes still owed by the block, oldest first
   list_rsp_type expected_outcomes [$];
   list_rsp_type head_outcome;

   // handles reused often so that finds and removes hit
   logic [HANDLE_IN_W-1:0] handle_pool [POOL_SIZE];

   // pacing controls
   logic burst_mode = 1'b0;
   logic hold_go = 1'b0;
   logic rsp_hold = 1'b0;
   int   rsp_gap = 0;
   int   rsp_next_gap = 0;

   // run statistics
   int mismatches = 0;
   int n_sent = 0;
   int n_checked = 0;
   int n_full = 0;
   int n_refused = 0;

   // directed stimulus
   dir_row_type dir_rows [NUM_DIR] = '{
      // right after reset with frozen cleared: empty list cases
      '{1'b1, 1'b0, FUNC_FIND,       32'h0000_0000, 5'd0,  5'd0,  1'b1, STAT_REFUSED, 5'd0},
      '{1'b0, 1'b0, FUNC_REMOVE,     32'h0000_0005, 5'd0,  5'd0,  1'b1, STAT_REFUSED, 5'd0},
      '{1'b0, 1'b0, FUNC_EXCHANGE,   32'h0000_0000, 5'd0,  5'd0,  1'b1, STAT_REFUSED, 5'd0},
      // insert past the end, then at the end which acts as add
      '{1'b0, 1'b0, FUNC_INSERT,     32'h0000_0001, 5'd1,  5'd0,  1'b1, STAT_REFUSED, 5'd0},
      '{1'b0, 1'b0, FUNC_INSERT,     32'hFFFF_FFFF, 5'd0,  5'd0,  1'b1, STAT_DONE,    5'd1},
      // duplicate add refused, new handle appended
      '{1'b0, 1'b0, FUNC_ADD,        32'hFFFF_FFFF, 5'd0,  5'd0,  1'b1, STAT_REFUSED, 5'd1},
      '{1'b0, 1'b0, FUNC_ADD,        32'h0000_0000, 5'd0,  5'd0,  1'b1, STAT_DONE,    5'd2},
      // assign far past the end appends, inside overwrites with a duplicate
      '{1'b0, 1'b0, FUNC_ASSIGN,     32'h1234_5678, 5'd31, 5'd0,  1'b1, STAT_DONE,    5'd3},
      '{1'b0, 1'b0, FUNC_ASSIGN,     32'h0000_0000, 5'd0,  5'd0,  1'b1, STAT_DONE,    5'd3},
      '{1'b0, 1'b0, FUNC_FIND,       32'h0000_0000, 5'd0,  5'd0,  1'b0, STAT_DONE,    5'd0},
      '{1'b0, 1'b0, FUNC_EXCHANGE,   32'h0000_0000, 5'd0,  5'd2,  1'b0, STAT_DONE,    5'd0},
      // exchange with an index at or far past the count
      '{1'b0, 1'b0, FUNC_EXCHANGE,   32'h0000_0000, 5'd2,  5'd3,  1'b1, STAT_REFUSED, 5'd3},
      '{1'b0, 1'b0, FUNC_EXCHANGE,   32'h0000_0000, 5'd31, 5'd0,  1'b1, STAT_REFUSED, 5'd3},
      // insert of a held handle moves it, insert of a new one shifts
      '{1'b0, 1'b0, FUNC_INSERT,     32'h1234_5678, 5'd1,  5'd0,  1'b0, STAT_DONE,    5'd0},
      '{1'b0, 1'b0, FUNC_INSERT,     32'hAAAA_5555, 5'd0,  5'd0,  1'b0, STAT_DONE,    5'd0},
      '{1'b0, 1'b0, FUNC_REMOVE,     32'h0000_0000, 5'd0,  5'd0,  1'b0, STAT_DONE,    5'd0},
      // undefined code with every other field at its top
      '{1'b0, 1'b0, FUNC_UNDEF,      32'hFFFF_FFFF, 5'd31, 5'd31, 1'b0, STAT_DONE,    5'd0},
      '{1'b0, 1'b0, FUNC_REMOVE_ALL, 32'h0000_0000, 5'd0,  5'd0,  1'b1, STAT_DONE,    5'd0},
      // frozen: removes refused, insert of a held handle duplicates it
      '{1'b1, 1'b1, FUNC_ADD,        32'h0000_0007, 5'd0,  5'd0,  1'b1, STAT_DONE,    5'd1},
      '{1'b0, 1'b0, FUNC_REMOVE,     32'h0000_0007, 5'd0,  5'd0,  1'b1, STAT_REFUSED, 5'd1},
      '{1'b0, 1'b0, FUNC_REMOVE_ALL, 32'h0000_0000, 5'd0,  5'd0,  1'b1, STAT_REFUSED, 5'd1},
      '{1'b0, 1'b0, FUNC_INSERT,     32'h0000_0007, 5'd0,  5'd0,  1'b1, STAT_DONE,    5'd2},
      '{1'b0, 1'b0, FUNC_FIND,       32'h0000_0007, 5'd0,  5'd0,  1'b0, STAT_DONE,    5'd0},
      '{1'b0, 1'b0, FUNC_EXCHANGE,   32'h0000_0000, 5'd1,  5'd0,  1'b0, STAT_DONE,    5'd0},
      // thawed again: remove all clears the list
      '{1'b1, 1'b0, FUNC_REMOVE_ALL, 32'h0000_0000, 5'd0,  5'd0,  1'b1, STAT_DONE,    5'd0}
   };

   ordered_unique_handle_list dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_func           (req_func),
      .req_handle         (req_handle),
      .req_position       (req_position),
      .req_other_position (req_other_position),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_entry_count    (rsp_entry_count),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   // 2 ns period
   always #1 clock = ~clock;

   // ---------------------------------------------------------------
   // list predictor
   // ---------------------------------------------------------------

   function automatic bit shadow_holds(input logic [HANDLE_IN_W-1:0] h);
      int i;
      for (i = 0; i < shadow_count; i++)
         if (shadow_entries[i] == h) return 1'b1;
      return 1'b0;
   endfunction

   // append unless already held or full
   function automatic logic [STATUS_W-1:0] shadow_add(input logic [HANDLE_IN_W-1:0] h);
      if (shadow_holds(h)) return STAT_REFUSED;
      if (shadow_count >= DEPTH) return STAT_FULL;
      shadow_entries[shadow_count] = h;
      shadow_count++;
      return STAT_DONE;
   endfunction

   // unless frozen, drop the first match and close the gap, vacated slot goes to zero
   function automatic logic [STATUS_W-1:0] shadow_remove(input logic [HANDLE_IN_W-1:0] h);
      int i;
      int j;
      if (shadow_frozen) return STAT_REFUSED;
      for (i = 0; i < shadow_count; i++) begin
         if (shadow_entries[i] == h) begin
            for (j = i; j + 1 < shadow_count; j++) shadow_entries[j] = shadow_entries[j + 1];
            shadow_count--;
            shadow_entries[shadow_count] = '0;
            return STAT_DONE;
         end
      end
      return STAT_REFUSED;
   endfunction

   function automatic void apply_list_op(input list_req_type it, output list_rsp_type outcome);
      logic [STATUS_W-1:0]    st;
      logic [HANDLE_IN_W-1:0] tmp;
      int                     pos;
      int                     pos2;
      int                     i;
      st = STAT_REFUSED;
      pos = int'(it.pos);
      pos2 = int'(it.other_pos);
      case (it.func)
         FUNC_FIND: begin
            st = shadow_holds(it.handle) ? STAT_DONE : STAT_REFUSED;
         end
         FUNC_ADD: begin
            st = shadow_add(it.handle);
         end
         FUNC_REMOVE: begin
            st = shadow_remove(it.handle);
         end
         FUNC_REMOVE_ALL: begin
            if (!shadow_frozen) begin
               for (i = 0; i < DEPTH; i++) shadow_entries[i] = '0;
               shadow_count = 0;
               st = STAT_DONE;
            end
         end
         FUNC_INSERT: begin
            if (pos < shadow_count) begin
               // a held copy goes first unless frozen
               void'(shadow_remove(it.handle));
               if (shadow_count >= DEPTH) begin
                  st = STAT_FULL;
               end else begin
                  for (i = shadow_count; i > pos; i--) shadow_entries[i] = shadow_entries[i - 1];
                  shadow_entries[pos] = it.handle;
                  shadow_count++;
                  st = STAT_DONE;
               end
            end else if (pos == shadow_count) begin
               st = shadow_add(it.handle);
            end
         end
         FUNC_ASSIGN: begin
            if (pos < shadow_count) begin
               shadow_entries[pos] = it.handle;
               st = STAT_DONE;
            end else begin
               st = shadow_add(it.handle);
            end
         end
         FUNC_EXCHANGE: begin
            if (pos < shadow_count && pos2 < shadow_count) begin
               tmp = shadow_entries[pos];
               shadow_entries[pos] = shadow_entries[pos2];
               shadow_entries[pos2] = tmp;
               st = STAT_DONE;
            end
         end
         default: begin
            st = STAT_REFUSED;
         end
      endcase
      outcome.status = st;
      outcome.count = COUNT_OUT_W'(shadow_count);
   endfunction

   // ---------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------

   // idle cycles before the next item or response, none in burst phases
   function automatic int draw_gap();
      if (burst_mode) return 0;
      return $urandom_range(0, 10);
   endfunction

   // position mostly from 0 up to the current fill, sometimes anywhere in 0..31
   function automatic logic [POS_W-1:0] random_pos();
      if ($urandom_range(0, 4) == 0) return POS_W'($urandom_range(0, 31));
      return POS_W'($urandom_range(0, shadow_count));
   endfunction

   function automatic list_req_type random_item();
      list_req_type it;
      int           r;
      r = $urandom_range(0, 99);
      // adds outweigh removes so the list reaches full regularly
      if (r < 15) it.func = FUNC_FIND;
      else if (r < 40) it.func = FUNC_ADD;
      else if (r < 52) it.func = FUNC_REMOVE;
      else if (r < 54) it.func = FUNC_REMOVE_ALL;
      else if (r < 72) it.func = FUNC_INSERT;
      else if (r < 86) it.func = FUNC_ASSIGN;
      else if (r < 99) it.func = FUNC_EXCHANGE;
      else it.func = FUNC_UNDEF;
      if ($urandom_range(0, 3) == 0) it.handle = $urandom;
      else it.handle = handle_pool[$urandom_range(0, POOL_SIZE - 1)];
      it.pos = random_pos();
      it.other_pos = random_pos();
      return it;
   endfunction

   // offer one item, then update the shadow list and queue the outcome
   task automatic send_item(input list_req_type it, input bit fixed_exp,
                            input list_rsp_type fixed_rsp);
      int           gap;
      list_rsp_type predicted;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= it.func;
      req_handle <= it.handle;
      req_position <= it.pos;
      req_other_position <= it.other_pos;
      do @(posedge clock); while (!req_ready);
      apply_list_op(it, predicted);
      expected_outcomes.push_back(fixed_exp ? fixed_rsp : predicted);
      n_sent++;
   endtask

   // stop sending, wait until every outcome is back, then write frozen
   task automatic write_frozen(input logic value);
      req_valid <= 1'b0;
      while (expected_outcomes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      shadow_frozen = value;
   endtask

   // ---------------------------------------------------------------
   // response side
   // ---------------------------------------------------------------

   // receiver pacing: a random gap after each taken response, or a long hold
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_gap <= 0;
      end else if (rsp_hold) begin
         rsp_ready <= 1'b0;
      end else if (rsp_valid && rsp_ready) begin
         rsp_next_gap = draw_gap();
         rsp_gap <= rsp_next_gap;
         rsp_ready <= (rsp_next_gap == 0);
      end else if (rsp_gap != 0) begin
         rsp_gap <= rsp_gap - 1;
         rsp_ready <= (rsp_gap == 1);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // long receiver hold-off so the block backs up into its input
   initial begin
      while (!hold_go) @(posedge clock);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   // compare every taken response with the oldest outcome owed
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         n_checked++;
         if (expected_outcomes.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("response %0d with nothing outstanding: status %0d count %0d",
                        n_checked, rsp_status, rsp_entry_count);
         end else begin
            head_outcome = expected_outcomes.pop_front();
            if (rsp_status !== head_outcome.status ||
                rsp_entry_count !== head_outcome.count) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("response %0d: status exp %0d got %0d, count exp %0d got %0d",
                           n_checked, head_outcome.status, rsp_status,
                           head_outcome.count, rsp_entry_count);
            end
         end
         if (rsp_status == STAT_FULL) n_full++;
         if (rsp_status == STAT_REFUSED) n_refused++;
      end
   end

   // ---------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------

   initial begin
      int           k;
      int           p;
      list_req_type it;
      list_rsp_type typed_rsp;

      // shadow state after reset
      for (k = 0; k < DEPTH; k++) shadow_entries[k] = '0;
      shadow_count = 0;
      shadow_frozen = 1'b0;

      // handle pool with both extremes
      handle_pool[0] = '0;
      handle_pool[1] = '1;
      for (k = 2; k < POOL_SIZE; k++) handle_pool[k] = $urandom;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed rows
      for (k = 0; k < NUM_DIR; k++) begin
         if (dir_rows[k].set_cfg) write_frozen(dir_rows[k].cfg_val);
         it.func = dir_rows[k].func;
         it.handle = dir_rows[k].handle;
         it.pos = dir_rows[k].pos;
         it.other_pos = dir_rows[k].other_pos;
         typed_rsp.status = dir_rows[k].status;
         typed_rsp.count = dir_rows[k].count;
         send_item(it, dir_rows[k].fixed_exp, typed_rsp);
      end

      // random phases, each under its own frozen setting
      for (p = 0; p < NUM_PHASES; p++) begin
         write_frozen(PHASE_FROZEN[p]);
         // one phase with no idling on either side
         burst_mode = (p == 3);
         // receiver stalls for a long stretch while items keep coming
         if (p == 1) hold_go = 1'b1;
         for (k = 0; k < PHASE_ITEMS; k++) send_item(random_item(), 1'b0, '0);
      end

      // drain, then let any stray response show up
      req_valid <= 1'b0;
      while (expected_outcomes.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("ran %0d list operations in %0d frozen phases, %0d responses checked",
               n_sent, NUM_PHASES, n_checked);
      $display("%0d refused and %0d list-full responses seen, %0d mismatches",
               n_refused, n_full, mismatches);
      if (mismatches == 0 && expected_outcomes.size() == 0) begin
         $display("PASS ordered_unique_handle_list");
      end else begin
         $display("FAIL ordered_unique_handle_list");
      end
      $finish;
   end

   // watchdog, several times the slowest legal run
   initial begin
      #1_200_000;
      $display("FAIL ordered_unique_handle_list");
      $finish;
   end

endmodule

>>> files.f
rtl/core/olh_pkg.sv
rtl/core/olh_store.sv
rtl/core/olh_seq.sv
rtl/core/ordered_unique_handle_list.sv
tb/tb_ordered_unique_handle_list.sv
